>>> hdl/multi_slot_timeout_timer_unit_macros.svh
// Assertion macros for the multi-slot timeout timer.
`ifndef MULTI_SLOT_TIMEOUT_TIMER_UNIT_MACROS_SVH
`define MULTI_SLOT_TIMEOUT_TIMER_UNIT_MACROS_SVH

`ifndef SYNTHESIS
`define MSTT_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mstt assertion failed");
`define MSTT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mstt assertion failed");
`else
`define MSTT_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define MSTT_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

>>> hdl/mstt_pkg.sv
`default_nettype none

package mstt_pkg;

  localparam int SLOT_COUNT_DEF = 8;

  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_ARM   = 2'd1;
  localparam logic [1:0] OP_QUERY = 2'd2;

  localparam logic [15:0] DURATION_INFINITE = 16'hFFFF;

  typedef struct packed {
    logic [1:0]  opcode;
    logic        refresh_wake;
    logic [2:0]  slot_index;
    logic [15:0] deadline;
    logic [15:0] since_time;
    logic [15:0] duration_ms;
  } mstt_in_t;

  typedef struct packed {
    logic        schedule_request;
    logic [7:0]  woken_mask;
    logic [15:0] current_time;
    logic [15:0] elapsed_time;
    logic        has_elapsed;
  } mstt_out_t;

endpackage

`default_nettype wire

>>> hdl/mstt_slot_ram.sv
`default_nettype none

module mstt_slot_ram #(
  parameter int DEPTH = 8,
  parameter int AW    = 3,
  parameter int DW    = 16
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [DW-1:0] wdata,
  input  wire logic          re,
  input  wire logic [AW-1:0] raddr,
  output logic      [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

>>> hdl/multi_slot_timeout_timer_unit.sv
// Multi-slot timeout timer. A command is taken when start is high and busy is low; its
// result appears on out_result for exactly one cycle with out_strobe high, and the
// receiver cannot stall it. Arm, query and no-op commands answer in the cycle after the
// transfer and leave busy low. A tick holds busy high while the deadline memory is swept
// one slot per cycle through its single read port, and its result appears in the same
// cycle that busy falls. Deadlines sit in a synchronous memory; armed flags are registers
// cleared by reset.
`default_nettype none

`include "multi_slot_timeout_timer_unit_macros.svh"

module multi_slot_timeout_timer_unit #(
  parameter int SLOT_COUNT = mstt_pkg::SLOT_COUNT_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire mstt_pkg::mstt_in_t in_item,
  output logic                    out_strobe,
  output mstt_pkg::mstt_out_t     out_result
);

  import mstt_pkg::*;

  localparam int SLOT_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(SLOT_COUNT - 1);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_SCAN = 1'b1;

  logic                  state_r,   state_nxt;
  logic [15:0]           count_r,   count_nxt;
  logic [SLOT_COUNT-1:0] armed_r,   armed_nxt;
  logic [SLOT_W-1:0]     rd_idx_r,  rd_idx_nxt;
  logic                  rd_act_r,  rd_act_nxt;
  logic [SLOT_W-1:0]     cmp_idx_r, cmp_idx_nxt;
  logic                  cmp_vld_r, cmp_vld_nxt;
  logic                  wake_r,    wake_nxt;
  logic [7:0]            mask_r,    mask_nxt;
  logic                  strobe_r,  strobe_nxt;
  mstt_out_t             result_r,  result_nxt;

  logic              accept;
  logic              ram_we;
  logic [SLOT_W-1:0] ram_waddr;
  logic [15:0]       ram_rdata;
  logic              hit;
  logic [7:0]        hit_bits;
  logic [15:0]       elapsed;
  logic              arm_ok;

  assign busy      = (state_r == ST_SCAN);
  assign accept    = start && !busy;
  assign ram_waddr = SLOT_W'(in_item.slot_index);
  assign arm_ok    = (32'(in_item.slot_index) < SLOT_COUNT);
  assign elapsed   = count_r - in_item.since_time;

  // writes happen only when idle, reads only while sweeping: busy interlocks the port
  mstt_slot_ram #(
    .DEPTH (SLOT_COUNT),
    .AW    (SLOT_W),
    .DW    (16)
  ) u_slot_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (in_item.deadline),
    .re    (rd_act_r),
    .raddr (rd_idx_r),
    .rdata (ram_rdata)
  );

  assign hit = cmp_vld_r && armed_r[cmp_idx_r] && (ram_rdata == count_r);

  always_comb begin
    for (int b = 0; b < 8; b++) begin
      hit_bits[b] = hit && (32'(cmp_idx_r) == b);
    end
  end

  always_comb begin
    state_nxt   = state_r;
    count_nxt   = count_r;
    armed_nxt   = armed_r;
    rd_idx_nxt  = rd_idx_r;
    rd_act_nxt  = rd_act_r;
    cmp_idx_nxt = cmp_idx_r;
    cmp_vld_nxt = 1'b0;
    wake_nxt    = wake_r;
    mask_nxt    = mask_r;
    strobe_nxt  = 1'b0;
    result_nxt  = result_r;
    ram_we      = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          result_nxt              = '0;
          result_nxt.current_time = count_r;
          unique case (in_item.opcode)
            OP_TICK: begin
              count_nxt  = count_r + 16'd1;
              state_nxt  = ST_SCAN;
              rd_act_nxt = 1'b1;
              rd_idx_nxt = '0;
              wake_nxt   = in_item.refresh_wake;
              mask_nxt   = '0;
            end
            OP_ARM: begin
              strobe_nxt = 1'b1;
              if (arm_ok) begin
                ram_we               = 1'b1;
                armed_nxt[ram_waddr] = 1'b1;
              end
            end
            OP_QUERY: begin
              strobe_nxt              = 1'b1;
              result_nxt.elapsed_time = elapsed;
              result_nxt.has_elapsed  = (in_item.duration_ms != DURATION_INFINITE) &&
                                        (elapsed >= in_item.duration_ms);
            end
            default: begin
              strobe_nxt = 1'b1;
            end
          endcase
        end
      end
      ST_SCAN: begin
        if (rd_act_r) begin
          cmp_vld_nxt = 1'b1;
          cmp_idx_nxt = rd_idx_r;
          if (rd_idx_r == LAST_SLOT) begin
            rd_act_nxt = 1'b0;
          end else begin
            rd_idx_nxt = rd_idx_r + 1'b1;
          end
        end
        if (hit) begin
          armed_nxt[cmp_idx_r] = 1'b0;
        end
        wake_nxt = wake_r || hit;
        mask_nxt = mask_r | hit_bits;
        if (cmp_vld_r && (cmp_idx_r == LAST_SLOT)) begin
          state_nxt                   = ST_IDLE;
          strobe_nxt                  = 1'b1;
          result_nxt                  = '0;
          result_nxt.current_time     = count_r;
          result_nxt.schedule_request = wake_r || hit;
          result_nxt.woken_mask       = mask_r | hit_bits;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      count_r   <= '0;
      armed_r   <= '0;
      rd_act_r  <= 1'b0;
      cmp_vld_r <= 1'b0;
      strobe_r  <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      count_r   <= count_nxt;
      armed_r   <= armed_nxt;
      rd_act_r  <= rd_act_nxt;
      cmp_vld_r <= cmp_vld_nxt;
      strobe_r  <= strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rd_idx_r  <= rd_idx_nxt;
    cmp_idx_r <= cmp_idx_nxt;
    wake_r    <= wake_nxt;
    mask_r    <= mask_nxt;
    result_r  <= result_nxt;
  end

  assign out_strobe = strobe_r;
  assign out_result = result_r;

  `MSTT_ASSERT_NEXT(a_tick_goes_busy, clk, rst_n, accept && (in_item.opcode == OP_TICK), busy)
  `MSTT_ASSERT_SAME(a_result_when_idle, clk, rst_n, out_strobe, !busy)
  `MSTT_ASSERT_SAME(a_mask_implies_req, clk, rst_n,
                    out_strobe && (out_result.woken_mask != 8'd0),
                    out_result.schedule_request)
  `MSTT_ASSERT_SAME(a_idle_no_sweep, clk, rst_n, !busy, !rd_act_r && !cmp_vld_r)

endmodule

`default_nettype wire

>>> tb/tb.sv
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import mstt_pkg::*;

  localparam int SLOTS = SLOT_COUNT_DEF;
  localparam logic [1:0] OP_IDLE = 2'd3;
  localparam int RANDOM_ITEMS = 1530;
  localparam int QUIET_TAIL = 200;

  class timer_tracker;
    logic [15:0] ms_count;
    logic armed [SLOTS];
    logic [15:0] wake_at [SLOTS];
    mstt_out_t due_results[$];
    int errors;

    function new();
      ms_count = '0;
      foreach (armed[i]) begin
        armed[i] = 1'b0;
        wake_at[i] = '0;
      end
      errors = 0;
    endfunction

    function int pending_count();
      return due_results.size();
    endfunction

    // predict the result of an accepted command and move the timer state on
    function void take_command(mstt_in_t c);
      mstt_out_t r;
      logic woke;
      r = '0;
      woke = c.refresh_wake;
      case (c.opcode)
        OP_TICK: begin
          ms_count = ms_count + 16'd1;
          for (int i = 0; i < SLOTS; i++) begin
            if (armed[i] && wake_at[i] == ms_count) begin
              armed[i] = 1'b0;
              woke = 1'b1;
              if (i < 8) r.woken_mask[i] = 1'b1;
            end
          end
          r.schedule_request = woke;
        end
        OP_ARM: begin
          if (int'(c.slot_index) < SLOTS) begin
            wake_at[c.slot_index] = c.deadline;
            armed[c.slot_index] = 1'b1;
          end
        end
        OP_QUERY: begin
          r.elapsed_time = ms_count - c.since_time;
          r.has_elapsed = (c.duration_ms != DURATION_INFINITE) &&
                          (r.elapsed_time >= c.duration_ms);
        end
        default: ;
      endcase
      r.current_time = ms_count;
      due_results.push_back(r);
    endfunction

    function void compare_field(string field, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
        $display("%0t mismatch on %s: expected %0h actual %0h", $time, field, want, got);
        errors++;
      end
    endfunction

    function void match_result(mstt_out_t got);
      mstt_out_t want;
      if (due_results.size() == 0) begin
        $display("%0t result with nothing outstanding: expected none actual %h", $time, got);
        errors++;
        return;
      end
      want = due_results.pop_front();
      compare_field("schedule_request", 16'(want.schedule_request),
                    16'(got.schedule_request));
      compare_field("woken_mask", 16'(want.woken_mask), 16'(got.woken_mask));
      compare_field("current_time", want.current_time, got.current_time);
      compare_field("elapsed_time", want.elapsed_time, got.elapsed_time);
      compare_field("has_elapsed", 16'(want.has_elapsed), 16'(got.has_elapsed));
    endfunction

    function void flag_missing();
      foreach (due_results[i]) begin
        $display("%0t missing result: expected %h actual none", $time, due_results[i]);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  mstt_in_t in_item = '0;
  logic out_strobe;
  mstt_out_t out_result;

  timer_tracker tracker = new();

  multi_slot_timeout_timer_unit uut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_item(in_item),
    .out_strobe(out_strobe),
    .out_result(out_result)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && out_strobe === 1'b1) tracker.match_result(out_result);
  end

  function automatic mstt_in_t make_cmd(logic [1:0] op, logic refresh, logic [2:0] slot,
                                        logic [15:0] dl, logic [15:0] since,
                                        logic [15:0] dur);
    mstt_in_t c;
    c.opcode = op;
    c.refresh_wake = refresh;
    c.slot_index = slot;
    c.deadline = dl;
    c.since_time = since;
    c.duration_ms = dur;
    return c;
  endfunction

  function automatic mstt_in_t random_command();
    mstt_in_t c;
    int unsigned pick;
    logic [15:0] gap;
    c = make_cmd(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                 3'($urandom_range(0, 7)), 16'($urandom_range(0, 65535)),
                 16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
    pick = $urandom_range(0, 99);
    if (pick < 48) begin
      c.opcode = OP_TICK;
    end else if (pick < 68) begin
      c.opcode = OP_ARM;
      case ($urandom_range(0, 7))
        0: ;
        1: c.deadline = tracker.ms_count;
        default: c.deadline = tracker.ms_count + 16'($urandom_range(1, 16));
      endcase
    end else if (pick < 95) begin
      c.opcode = OP_QUERY;
      if ($urandom_range(0, 3) != 0)
        c.since_time = tracker.ms_count - 16'($urandom_range(0, 40));
      gap = tracker.ms_count - c.since_time;
      case ($urandom_range(0, 5))
        0: c.duration_ms = DURATION_INFINITE;
        1: c.duration_ms = DURATION_INFINITE - 16'd1;
        2: c.duration_ms = '0;
        3: ;
        default: c.duration_ms = gap + 16'($urandom_range(0, 2)) - 16'd1;
      endcase
    end else begin
      c.opcode = OP_IDLE;
    end
    return c;
  endfunction

  task automatic send_cmd(mstt_in_t c);
    @(negedge clk);
    start <= 1'b1;
    in_item <= c;
    do @(posedge clk); while (busy !== 1'b0);
    tracker.take_command(c);
  endtask

  task automatic hold_off(int cycles);
    @(negedge clk);
    start <= 1'b0;
    repeat (cycles - 1) @(negedge clk);
  endtask

  task automatic wait_drained();
    hold_off(1);
    while (tracker.pending_count() != 0) @(posedge clk);
  endtask

  initial begin
    mstt_in_t directed[$];
    int waited;

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    directed.push_back(make_cmd(OP_QUERY, 1'b0, 3'd0, 16'h0000, 16'h0000, 16'h0000));
    directed.push_back(make_cmd(OP_QUERY, 1'b1, 3'd7, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    directed.push_back(make_cmd(OP_QUERY, 1'b0, 3'd0, 16'h0000, 16'hFFFF, 16'h0001));
    directed.push_back(make_cmd(OP_TICK, 1'b0, 3'd0, 16'h0000, 16'h0000, 16'h0000));
    directed.push_back(make_cmd(OP_TICK, 1'b1, 3'd7, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    directed.push_back(make_cmd(OP_ARM, 1'b0, 3'd0, 16'd4, 16'h0000, 16'h0000));
    directed.push_back(make_cmd(OP_ARM, 1'b1, 3'd7, 16'd4, 16'hFFFF, 16'hFFFF));
    directed.push_back(make_cmd(OP_ARM, 1'b0, 3'd3, 16'hFFFF, 16'h0000, 16'h0000));
    // re-arm overwrites the earlier deadline
    directed.push_back(make_cmd(OP_ARM, 1'b0, 3'd3, 16'd5, 16'h0000, 16'h0000));
    // deadline equal to the count: must not wake until a full wrap
    directed.push_back(make_cmd(OP_ARM, 1'b0, 3'd5, 16'd2, 16'h0000, 16'h0000));
    directed.push_back(make_cmd(OP_TICK, 1'b0, 3'd5, 16'h0002, 16'h0000, 16'h0000));
    directed.push_back(make_cmd(OP_TICK, 1'b0, 3'd0, 16'h0000, 16'h0000, 16'h0000));
    directed.push_back(make_cmd(OP_TICK, 1'b0, 3'd0, 16'h0000, 16'h0000, 16'h0000));
    directed.push_back(make_cmd(OP_IDLE, 1'b1, 3'd7, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    directed.push_back(make_cmd(OP_QUERY, 1'b0, 3'd0, 16'h0000, 16'h0000, 16'hFFFE));
    directed.push_back(make_cmd(OP_QUERY, 1'b0, 3'd0, 16'h0000, 16'd6, 16'hFFFE));
    directed.push_back(make_cmd(OP_ARM, 1'b0, 3'd1, 16'd6, 16'h0000, 16'h0000));
    directed.push_back(make_cmd(OP_ARM, 1'b0, 3'd2, 16'd6, 16'h0000, 16'h0000));
    directed.push_back(make_cmd(OP_ARM, 1'b0, 3'd4, 16'd6, 16'h0000, 16'h0000));
    directed.push_back(make_cmd(OP_ARM, 1'b0, 3'd6, 16'd6, 16'h0000, 16'h0000));
    directed.push_back(make_cmd(OP_TICK, 1'b1, 3'd0, 16'h0000, 16'h0000, 16'h0000));
    directed.push_back(make_cmd(OP_TICK, 1'b0, 3'd0, 16'h0000, 16'h0000, 16'h0000));

    foreach (directed[i]) send_cmd(directed[i]);
    wait_drained();

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == RANDOM_ITEMS / 2) wait_drained();
      if (i < RANDOM_ITEMS - QUIET_TAIL && (i / 150) % 3 != 2 && $urandom_range(0, 3) == 0)
        hold_off($urandom_range(1, 13));
      send_cmd(random_command());
    end

    hold_off(1);
    waited = 0;
    while (tracker.pending_count() != 0 && waited < 2000) begin
      @(posedge clk);
      waited++;
    end
    tracker.flag_missing();
    repeat (30) @(posedge clk);

    if (tracker.errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule

`default_nettype wire
